// ----- design/ctpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar tick unit package
// Shared types and constants for the calendar counter and its backup writes.
// ----------------------------------------------------------------------------
package ctpw_pkg;

    localparam int CFG_W   = 8;
    localparam int ADDR_W  = 3;
    localparam int VALUE_W = 7;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // Backup store addresses, in the order in which a burst emits them.
    localparam logic [ADDR_W-1:0] ADDR_YEAR    = 3'd1;
    localparam logic [ADDR_W-1:0] ADDR_MONTH   = 3'd2;
    localparam logic [ADDR_W-1:0] ADDR_DAY     = 3'd3;
    localparam logic [ADDR_W-1:0] ADDR_WEEKDAY = 3'd4;
    localparam logic [ADDR_W-1:0] ADDR_HOUR    = 3'd5;
    localparam logic [ADDR_W-1:0] ADDR_MINUTE  = 3'd6;
    localparam logic [ADDR_W-1:0] ADDR_SECOND  = 3'd7;

    localparam logic [CFG_W-1:0] TPS_RESET = 8'd20;

    // Snapshot of the calendar after a completed second, plus the first
    // address of the write burst it causes.
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [6:0]        year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [2:0]        weekday;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } cal_desc_t;

endpackage

// ----- design/ctpw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar tick front end
// Takes ticks, runs the prescaler and calendar counters, and queues one
// write-burst descriptor for every completed second.
// ----------------------------------------------------------------------------
module ctpw_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [ctpw_pkg::CFG_W-1:0] tps,
    input  logic                     tick_valid,
    input  logic                     tick_enable,
    output logic                     tick_ready,
    input  logic                     q_full,
    output logic                     q_push,
    output ctpw_pkg::cal_desc_t      q_desc
);
    import ctpw_pkg::*;

    logic [7:0] tick_reg,    tick_next;
    logic [5:0] second_reg,  second_next;
    logic [5:0] minute_reg,  minute_next;
    logic [4:0] hour_reg,    hour_next;
    logic [2:0] weekday_reg, weekday_next;
    logic [4:0] day_reg,     day_next;
    logic [3:0] month_reg,   month_next;
    logic [6:0] year_reg,    year_next;

    logic [8:0] tick_inc;
    logic       accept;
    logic       sec_done;
    logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

    assign tick_ready = !q_full;
    assign accept     = tick_valid && tick_ready && tick_enable;
    assign tick_inc   = {1'b0, tick_reg} + 9'd1;
    // A register lowered below the current count completes the second at once.
    assign sec_done   = tick_inc >= {1'b0, tps};

    assign sec_wrap   = second_reg >= 6'd59;
    assign min_wrap   = sec_wrap  && (minute_reg >= 6'd59);
    assign hour_wrap  = min_wrap  && (hour_reg >= 5'd23);
    assign day_wrap   = hour_wrap && (day_reg >= 5'd31);
    assign month_wrap = day_wrap  && (month_reg >= 4'd12);

    always_comb begin
        tick_next    = tick_reg;
        second_next  = second_reg;
        minute_next  = minute_reg;
        hour_next    = hour_reg;
        weekday_next = weekday_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        if (accept) begin
            if (!sec_done) begin
                tick_next = tick_inc[7:0];
            end else begin
                tick_next   = 8'd0;
                second_next = sec_wrap ? 6'd0 : second_reg + 6'd1;
                if (sec_wrap) begin
                    minute_next = min_wrap ? 6'd0 : minute_reg + 6'd1;
                end
                if (min_wrap) begin
                    hour_next = hour_wrap ? 5'd0 : hour_reg + 5'd1;
                end
                if (hour_wrap) begin
                    weekday_next = (weekday_reg >= 3'd7) ? 3'd1 : weekday_reg + 3'd1;
                    day_next     = day_wrap ? 5'd1 : day_reg + 5'd1;
                end
                if (day_wrap) begin
                    month_next = month_wrap ? 4'd1 : month_reg + 4'd1;
                end
                if (month_wrap) begin
                    year_next = (year_reg >= 7'd99) ? 7'd0 : year_reg + 7'd1;
                end
            end
        end
    end

    always_comb begin
        q_push            = accept && sec_done;
        q_desc.year       = year_next;
        q_desc.month      = month_next;
        q_desc.day        = day_next;
        q_desc.weekday    = weekday_next;
        q_desc.hour       = hour_next;
        q_desc.minute     = minute_next;
        q_desc.second     = second_next;
        if (month_wrap) begin
            q_desc.start_addr = ADDR_YEAR;
        end else if (day_wrap) begin
            q_desc.start_addr = ADDR_MONTH;
        end else if (hour_wrap) begin
            q_desc.start_addr = ADDR_DAY;
        end else if (min_wrap) begin
            q_desc.start_addr = ADDR_HOUR;
        end else if (sec_wrap) begin
            q_desc.start_addr = ADDR_MINUTE;
        end else begin
            q_desc.start_addr = ADDR_SECOND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= 8'd0;
            second_reg  <= 6'd0;
            minute_reg  <= 6'd0;
            hour_reg    <= 5'd12;
            weekday_reg <= 3'd1;
            day_reg     <= 5'd31;
            month_reg   <= 4'd1;
            year_reg    <= 7'd16;
        end else begin
            tick_reg    <= tick_next;
            second_reg  <= second_next;
            minute_reg  <= minute_next;
            hour_reg    <= hour_next;
            weekday_reg <= weekday_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
        end
    end

endmodule

// ----- design/ctpw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar descriptor queue
// Short first-in first-out buffer between the front end and the write engine.
// ----------------------------------------------------------------------------
module ctpw_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ctpw_pkg::cal_desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output ctpw_pkg::cal_desc_t pop_desc
);
    import ctpw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cal_desc_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_desc  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- design/ctpw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar write engine
// Turns each queued descriptor into its burst of backup-store writes.
// ----------------------------------------------------------------------------
module ctpw_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_not_empty,
    input  ctpw_pkg::cal_desc_t              q_desc,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ctpw_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import ctpw_pkg::*;

    cal_desc_t         desc_reg,  desc_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic              busy_reg,  busy_next;
    logic              burst_end;
    logic [VALUE_W-1:0] value;

    // Addresses run upward from the start address and always end at the second.
    assign burst_end = addr_reg == ADDR_SECOND;
    assign q_pop     = q_not_empty && (!busy_reg || (m_tready && burst_end));

    always_comb begin
        desc_next = desc_reg;
        addr_next = addr_reg;
        busy_next = busy_reg;
        if (q_pop) begin
            desc_next = q_desc;
            addr_next = q_desc.start_addr;
            busy_next = 1'b1;
        end else if (busy_reg && m_tready) begin
            if (burst_end) begin
                busy_next = 1'b0;
            end else begin
                addr_next = addr_reg + ADDR_W'(1);
            end
        end
    end

    always_comb begin
        case (addr_reg)
            ADDR_YEAR:    value = desc_reg.year;
            ADDR_MONTH:   value = {3'd0, desc_reg.month};
            ADDR_DAY:     value = {2'd0, desc_reg.day};
            ADDR_WEEKDAY: value = {4'd0, desc_reg.weekday};
            ADDR_HOUR:    value = {2'd0, desc_reg.hour};
            ADDR_MINUTE:  value = {1'b0, desc_reg.minute};
            ADDR_SECOND:  value = {1'b0, desc_reg.second};
            default:      value = '0;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = burst_end;
    assign m_tdata  = {(M_DATA_W - ADDR_W - VALUE_W)'(0), value, addr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            addr_reg <= ADDR_SECOND;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

endmodule

// ----- design/calendar_tick_with_persist_writes_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar tick unit
// Calendar clock counter that emits backup-store writes for changed fields.
// ----------------------------------------------------------------------------
// Each input transfer is one timer tick, taken at one tick per clock as long
// as the descriptor queue has room. Every completed second queues one
// descriptor; the write engine then sends one write per cycle while tready
// is high, from 1 write (second only) up to 7 (year rollover), last write
// flagged on tlast. Ticks keep flowing while a burst drains; the input stalls
// only when QUEUE_DEPTH seconds are waiting, which takes a prescaler count
// below 7 or a receiver that holds off tready. ticks_per_second is written
// through the cfg port and is meant to change only while no burst is pending.
// ----------------------------------------------------------------------------
module calendar_tick_with_persist_writes_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctpw_pkg::CFG_W-1:0]     cfg_data,    // ticks_per_second
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctpw_pkg::S_DATA_W-1:0]  s_tdata,     // [0] count_enable
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ctpw_pkg::M_DATA_W-1:0]  m_tdata,     // [2:0] store_address, [9:3] store_value
    output logic                           m_tlast      // last
);
    import ctpw_pkg::*;

    logic [CFG_W-1:0] tps_reg;
    logic             q_push, q_full, q_pop, q_not_empty;
    cal_desc_t        push_desc, pop_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= TPS_RESET;
        end else if (cfg_valid) begin
            tps_reg <= cfg_data;
        end
    end

    ctpw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tps         (tps_reg),
        .tick_valid  (s_tvalid),
        .tick_enable (s_tdata[0]),
        .tick_ready  (s_tready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (push_desc)
    );

    ctpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_desc  (pop_desc)
    );

    ctpw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_desc      (pop_desc),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- design/ctpw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar tick unit checker
// Port-level assertions on the write stream, bound to the top level.
// ----------------------------------------------------------------------------
module ctpw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled write holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("write changed while stalled");

    // Every burst ends with the second, and only the second ends it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'd7)))
        else $error("tlast does not match the second write");

    // A burst that is not finished continues in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("burst broken off");

    // Addresses are never zero and the padding stays clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != 3'd0) && (m_tdata[15:10] == 6'd0))
        else $error("bad address or padding");

endmodule

bind calendar_tick_with_persist_writes_unit ctpw_checker u_ctpw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar tick unit testbench
// Streams timer ticks into the calendar counter, predicts the backup-store
// write bursts of every completed second, and checks each write in order.
// ----------------------------------------------------------------------------
module testbench;
    import ctpw_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic [1:0] {JOB_TICK, JOB_CONFIG, JOB_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t        kind;
        logic [CFG_W-1:0] value;
        bit               idle_ok;
    } tick_job_t;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               last;
    } store_write_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    tick_job_t    tick_job_q[$];
    store_write_t store_write_q[$];

    // Predicted calendar state.
    logic [CFG_W-1:0] ticks_per_second_q = TPS_RESET;
    logic [7:0]       tick_prescale = 8'd0;
    logic [5:0]       cal_second    = 6'd0;
    logic [5:0]       cal_minute    = 6'd0;
    logic [4:0]       cal_hour      = 5'd12;
    logic [2:0]       cal_weekday   = 3'd1;
    logic [4:0]       cal_day       = 5'd31;
    logic [3:0]       cal_month     = 4'd1;
    logic [6:0]       cal_year      = 7'd16;

    bit tick_taken  = 1'b0;
    bit cfg_taken   = 1'b0;
    bit run_started = 1'b0;
    bit idle_ok     = 1'b1;
    int quiet_cycles = 0;
    int stuck_cycles = 0;
    int tick_gap     = 0;
    int rx_stall     = 0;
    int fail_count   = 0;

    calendar_tick_with_persist_writes_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void push_store_write(logic [ADDR_W-1:0] addr,
                                             logic [VALUE_W-1:0] value);
        store_write_t w;
        w.addr  = addr;
        w.value = value;
        w.last  = 1'b0;
        store_write_q.push_back(w);
    endfunction

    // Advances the calendar by one tick and queues the writes it causes.
    function automatic void count_tick(logic enable);
        bit carry_minute, carry_hour, carry_day, carry_month, carry_year;
        carry_minute = 1'b0;
        carry_hour   = 1'b0;
        carry_day    = 1'b0;
        carry_month  = 1'b0;
        carry_year   = 1'b0;
        if (!enable) return;
        // The prescaler never exceeds 254 here, so the increment cannot wrap.
        tick_prescale = tick_prescale + 8'd1;
        if (tick_prescale < ticks_per_second_q) return;
        tick_prescale = 8'd0;

        if (cal_second == 6'd59) begin
            cal_second = 6'd0;
            carry_minute = 1'b1;
            if (cal_minute == 6'd59) begin
                cal_minute = 6'd0;
                carry_hour = 1'b1;
                if (cal_hour == 5'd23) begin
                    cal_hour = 5'd0;
                    carry_day = 1'b1;
                    cal_weekday = (cal_weekday == 3'd7) ? 3'd1 : cal_weekday + 3'd1;
                    if (cal_day == 5'd31) begin
                        cal_day = 5'd1;
                        carry_month = 1'b1;
                        if (cal_month == 4'd12) begin
                            cal_month = 4'd1;
                            carry_year = 1'b1;
                            cal_year = (cal_year == 7'd99) ? 7'd0 : cal_year + 7'd1;
                        end else begin
                            cal_month = cal_month + 4'd1;
                        end
                    end else begin
                        cal_day = cal_day + 5'd1;
                    end
                end else begin
                    cal_hour = cal_hour + 5'd1;
                end
            end else begin
                cal_minute = cal_minute + 6'd1;
            end
        end else begin
            cal_second = cal_second + 6'd1;
        end

        if (carry_year) push_store_write(ADDR_YEAR, cal_year);
        if (carry_month) push_store_write(ADDR_MONTH, VALUE_W'(cal_month));
        if (carry_day) begin
            push_store_write(ADDR_DAY, VALUE_W'(cal_day));
            push_store_write(ADDR_WEEKDAY, VALUE_W'(cal_weekday));
        end
        if (carry_hour) push_store_write(ADDR_HOUR, VALUE_W'(cal_hour));
        if (carry_minute) push_store_write(ADDR_MINUTE, VALUE_W'(cal_minute));
        push_store_write(ADDR_SECOND, VALUE_W'(cal_second));
        store_write_q[store_write_q.size()-1].last = 1'b1;
    endfunction

    task automatic queue_job(job_kind_t kind, logic [CFG_W-1:0] value, bit idle);
        tick_job_t j;
        j.kind    = kind;
        j.value   = value;
        j.idle_ok = idle;
        tick_job_q.push_back(j);
    endtask

    // Monitor and predictor: everything is sampled at the rising edge.
    always @(posedge aclk) begin
        store_write_t want;
        bit           write_taken;
        if (aresetn) begin
            tick_taken  = s_tvalid && s_tready;
            cfg_taken   = cfg_valid && cfg_ready;
            write_taken = m_tvalid && m_tready;
            if (write_taken) begin
                if (store_write_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected store write: expected none, %s %0d %0d %0d",
                             $time, "actual addr value last",
                             m_tdata[2:0], m_tdata[9:3], m_tlast);
                end else begin
                    want = store_write_q.pop_front();
                    if (m_tdata[2:0] !== want.addr || m_tdata[9:3] !== want.value ||
                        m_tlast !== want.last) begin
                        fail_count++;
                        $display("%0t: store write mismatch: expected addr %0d value %0d last %0d,",
                                 $time, want.addr, want.value, want.last);
                        $display("%0t:     actual addr %0d value %0d last %0d",
                                 $time, m_tdata[2:0], m_tdata[9:3], m_tlast);
                    end
                end
            end
            if (cfg_taken) ticks_per_second_q = cfg_data;
            if (tick_taken) count_tick(s_tdata[0]);

            if (tick_taken || write_taken) quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;

            if (tick_taken || cfg_taken || write_taken) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no transfer for %0d cycles", $time, stuck_cycles);
                $display("calendar_tick_with_persist_writes_unit regression: fail");
                $finish;
            end
        end
    end

    // Driver for ticks, register writes and the receiver's ready.
    always @(negedge aclk) begin
        logic next_tvalid, next_cfg_valid, next_tready;
        bit   calendar_idle;
        next_tvalid    = s_tvalid && !tick_taken;
        next_cfg_valid = cfg_valid && !cfg_taken;
        // A tick that causes no write may still be in flight, hence the settle time.
        calendar_idle  = store_write_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
        if (run_started && !next_tvalid && !next_cfg_valid) begin
            if (tick_gap != 0) begin
                tick_gap--;
            end else if (tick_job_q.size() != 0) begin
                idle_ok = tick_job_q[0].idle_ok;
                case (tick_job_q[0].kind)
                    JOB_TICK: begin
                        next_tvalid = 1'b1;
                        s_tdata <= {{(S_DATA_W-1){1'b0}}, tick_job_q[0].value[0]};
                        void'(tick_job_q.pop_front());
                        if (idle_ok && $urandom_range(0, 3) == 0)
                            tick_gap = $urandom_range(1, 5);
                    end
                    JOB_CONFIG: begin
                        if (calendar_idle) begin
                            next_cfg_valid = 1'b1;
                            cfg_data <= tick_job_q[0].value;
                            void'(tick_job_q.pop_front());
                        end
                    end
                    default: begin
                        if (calendar_idle) void'(tick_job_q.pop_front());
                    end
                endcase
            end
        end

        if (rx_stall != 0) begin
            rx_stall--;
            next_tready = 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(0, 4);
            next_tready = 1'b0;
        end else begin
            next_tready = 1'b1;
        end

        s_tvalid  <= next_tvalid;
        cfg_valid <= next_cfg_valid;
        m_tready  <= next_tready;
    end

    initial begin
        logic [CFG_W-1:0] tps;

        // Directed: disabled ticks, one second at the reset count, the
        // shortest second, then a count lowered below the running prescaler.
        queue_job(JOB_TICK, 8'd0, 1'b1);
        queue_job(JOB_TICK, 8'd0, 1'b1);
        for (int i = 0; i < 20; i++) begin
            queue_job(JOB_TICK, 8'd1, 1'b1);
            if (i == 9) queue_job(JOB_TICK, 8'd0, 1'b1);
        end
        queue_job(JOB_DRAIN, 8'd0, 1'b1);
        queue_job(JOB_CONFIG, 8'd1, 1'b1);
        queue_job(JOB_TICK, 8'd1, 1'b1);
        queue_job(JOB_TICK, 8'd0, 1'b1);
        queue_job(JOB_TICK, 8'd1, 1'b1);
        queue_job(JOB_CONFIG, 8'd255, 1'b1);
        for (int i = 0; i < 10; i++) queue_job(JOB_TICK, 8'd1, 1'b1);
        queue_job(JOB_CONFIG, 8'd4, 1'b1);
        queue_job(JOB_TICK, 8'd1, 1'b1);

        // One second per tick for a couple of minutes of calendar time, so
        // the minute carry occurs.
        queue_job(JOB_CONFIG, 8'd1, 1'b1);
        for (int c = 0; c < 4; c++) begin
            bit idle;
            idle = $urandom_range(0, 3) != 0;
            for (int i = 0; i < 35; i++)
                queue_job(JOB_TICK, 8'($urandom_range(0, 31) != 0), idle);
            if (c == 1) queue_job(JOB_DRAIN, 8'd0, idle);
        end

        // Random counts, often below the prescaler left by the phase before.
        for (int p = 0; p < 9; p++) begin
            case ($urandom_range(0, 3))
                0: tps = 8'd1;
                1: tps = 8'd255;
                2: tps = 8'($urandom_range(2, 6));
                default: tps = 8'($urandom_range(7, 254));
            endcase
            if (p == 8) tps = 8'($urandom_range(2, 6));
            queue_job(JOB_CONFIG, tps, p != 8);
            for (int i = 0; i < 20; i++)
                queue_job(JOB_TICK, 8'($urandom_range(0, 3) != 0), p != 8);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_started = 1'b1;

        while (tick_job_q.size() != 0 || s_tvalid || cfg_valid || store_write_q.size() != 0)
            @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (fail_count == 0)
            $display("calendar_tick_with_persist_writes_unit regression: pass");
        else
            $display("calendar_tick_with_persist_writes_unit regression: fail");
        $finish;
    end

endmodule
